// ===== hw/rtl/scored_table_admission_policy_core_macros.svh =====
// Assertion macros for the scored table admission policy core.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SCORED_TABLE_ADMISSION_POLICY_CORE_MACROS_SVH
`define SCORED_TABLE_ADMISSION_POLICY_CORE_MACROS_SVH

// Same-cycle implication.
`define STAP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define STAP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/stap_pkg.sv =====
// Shared types and codes for the scored table admission policy core.
// No dependencies.
`default_nettype none

package stap_pkg;

    localparam logic [2:0] CMD_INGEST  = 3'd0;
    localparam logic [2:0] CMD_USE     = 3'd1;
    localparam logic [2:0] CMD_PIN     = 3'd2;
    localparam logic [2:0] CMD_REMOVE  = 3'd3;
    localparam logic [2:0] CMD_COUNT   = 3'd4;

    localparam logic [2:0] ST_DONE       = 3'd0;
    localparam logic [2:0] ST_BELOW      = 3'd1;
    localparam logic [2:0] ST_ALL_PINNED = 3'd2;
    localparam logic [2:0] ST_NOT_BETTER = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
    localparam logic [2:0] ST_PINNED     = 3'd5;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_ROLE_CAP  = 2'd1;

    localparam logic [15:0] USE_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_APPLY
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     drop_en;
        logic     wr_en;
        logic     mod_pin;
        logic     mod_use;
        logic     pin_val;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== hw/rtl/stap_cell.sv =====
// One table slot of the admission policy chain; takes its neighbor's slot on
// rotate or close-up. Depends on stap_pkg.
`default_nettype none

module stap_cell #(
    parameter int INDEX    = 0,
    parameter int KEY_BITS = 32,
    parameter int IDX_W    = 7
) (
    input  wire                      i_clk,
    input  stap_pkg::t_cell_ctrl     i_ctrl,
    input  wire  [IDX_W-1:0]         i_drop_pos,
    input  wire  [IDX_W-1:0]         i_wr_pos,
    input  wire  [IDX_W-1:0]         i_mod_pos,
    input  wire  [KEY_BITS-1:0]      i_nxt_key,
    input  wire  [15:0]              i_nxt_score,
    input  wire  [2:0]               i_nxt_role,
    input  wire                      i_nxt_pin,
    input  wire  [15:0]              i_nxt_use,
    input  wire  [KEY_BITS-1:0]      i_new_key,
    input  wire  [15:0]              i_new_score,
    input  wire  [2:0]               i_new_role,
    output logic [KEY_BITS-1:0]      o_key,
    output logic [15:0]              o_score,
    output logic [2:0]               o_role,
    output logic                     o_pin,
    output logic [15:0]              o_use
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [KEY_BITS-1:0] r_key,   n_key;
    logic [15:0]         r_score, n_score;
    logic [2:0]          r_role,  n_role;
    logic                r_pin,   n_pin;
    logic [15:0]         r_use,   n_use;

    always_comb begin
        n_key   = r_key;
        n_score = r_score;
        n_role  = r_role;
        n_pin   = r_pin;
        n_use   = r_use;
        case (i_ctrl.op)
            stap_pkg::CELL_ROTATE: begin
                n_key   = i_nxt_key;
                n_score = i_nxt_score;
                n_role  = i_nxt_role;
                n_pin   = i_nxt_pin;
                n_use   = i_nxt_use;
            end
            stap_pkg::CELL_APPLY: begin
                if (i_ctrl.wr_en && (MY_IDX == i_wr_pos)) begin
                    n_key   = i_new_key;
                    n_score = i_new_score;
                    n_role  = i_new_role;
                    n_pin   = 1'b0;
                    n_use   = 16'd0;
                end else if (i_ctrl.drop_en && (MY_IDX >= i_drop_pos)) begin
                    n_key   = i_nxt_key;
                    n_score = i_nxt_score;
                    n_role  = i_nxt_role;
                    n_pin   = i_nxt_pin;
                    n_use   = i_nxt_use;
                end else if (MY_IDX == i_mod_pos) begin
                    if (i_ctrl.mod_pin) begin
                        n_pin = i_ctrl.pin_val;
                    end
                    if (i_ctrl.mod_use && (r_use != stap_pkg::USE_MAX)) begin
                        n_use = r_use + 16'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_score <= n_score;
        r_role  <= n_role;
        r_pin   <= n_pin;
        r_use   <= n_use;
    end

    assign o_key   = r_key;
    assign o_score = r_score;
    assign o_role  = r_role;
    assign o_pin   = r_pin;
    assign o_use   = r_use;

endmodule

`default_nettype wire

// ===== hw/rtl/scored_table_admission_policy_core.sv =====
// Top level of the scored table admission policy core: control, scan
// accumulators and the ring of stap_cell slots. Depends on stap_pkg, stap_cell
// and scored_table_admission_policy_core_macros.svh.
//
//  channel   | handshake                         | payload
//  ----------+-----------------------------------+--------------------------------------
//  request   | start in, busy out                | i_command, i_entry_role, i_entry_score,
//            |                                   | i_entry_key, i_favorite_value
//  result    | o_result_valid (one-cycle strobe) | o_status, o_evicted, o_evicted_key,
//            |                                   | o_role_count, o_use_count
//  config    | i_cfg_valid / o_cfg_ready         | i_cfg_index, i_cfg_data
//
// For each request the slot ring rotates once all the way round (one slot
// past the head per cycle), then the apply state edits and closes up the
// table, then the result strobe shows while the next request may already be
// taken.
// Reset (synchronous, i_rst_n low) clears the entry count and the control;
// slot contents are left as they are, since only slots below the count are read.
// The receiver cannot stall results; config writes are taken at any time.
`default_nettype none
`include "scored_table_admission_policy_core_macros.svh"

module scored_table_admission_policy_core #(
    parameter int ROLE_COUNT    = 8,
    parameter int MAX_PER_ROLE  = 16,
    parameter int TABLE_ENTRIES = 128,
    parameter int KEY_BITS      = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [2:0]  i_command,
    input  wire  [2:0]  i_entry_role,
    input  wire  [15:0] i_entry_score,
    input  wire  [31:0] i_entry_key,
    input  wire         i_favorite_value,
    output logic        o_result_valid,
    output logic [2:0]  o_status,
    output logic        o_evicted,
    output logic [31:0] o_evicted_key,
    output logic [4:0]  o_role_count,
    output logic [15:0] o_use_count,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // ---------------------------------------------------------------
    // State and request registers
    // ---------------------------------------------------------------
    stap_pkg::t_state r_state, n_state;

    logic [15:0]         r_threshold;
    logic [4:0]          r_role_cap;
    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    r_k;

    logic [2:0]          r_cmd;
    logic [2:0]          r_role;
    logic [15:0]         r_score;
    logic [KEY_BITS-1:0] r_key;
    logic                r_fav;

    // scan accumulators
    logic [CNT_W-1:0]    r_cnt;
    logic                r_weak_found;
    logic [IDX_W-1:0]    r_weak_pos;
    logic [15:0]         r_weak_score;
    logic [KEY_BITS-1:0] r_weak_key;
    logic                r_found;
    logic [IDX_W-1:0]    r_fpos;
    logic                r_fpin;
    logic [15:0]         r_fuse;

    // result registers
    logic                r_res_valid;
    logic [2:0]          r_res_status;
    logic                r_res_evicted;
    logic [31:0]         r_res_evkey;
    logic [4:0]          r_res_rc;
    logic [15:0]         r_res_uses;

    // ---------------------------------------------------------------
    // Slot ring
    // ---------------------------------------------------------------
    logic [KEY_BITS-1:0] w_key   [TABLE_ENTRIES];
    logic [15:0]         w_score [TABLE_ENTRIES];
    logic [2:0]          w_role  [TABLE_ENTRIES];
    logic                w_pin   [TABLE_ENTRIES];
    logic [15:0]         w_use   [TABLE_ENTRIES];

    stap_pkg::t_cell_ctrl cell_ctrl;
    logic [IDX_W-1:0]     d_drop_pos;
    logic [IDX_W-1:0]     d_wr_pos;
    logic [IDX_W-1:0]     d_mod_pos;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        localparam int NXT = (g + 1) % TABLE_ENTRIES;
        stap_cell #(
            .INDEX    (g),
            .KEY_BITS (KEY_BITS),
            .IDX_W    (IDX_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (cell_ctrl),
            .i_drop_pos  (d_drop_pos),
            .i_wr_pos    (d_wr_pos),
            .i_mod_pos   (d_mod_pos),
            .i_nxt_key   (w_key[NXT]),
            .i_nxt_score (w_score[NXT]),
            .i_nxt_role  (w_role[NXT]),
            .i_nxt_pin   (w_pin[NXT]),
            .i_nxt_use   (w_use[NXT]),
            .i_new_key   (r_key),
            .i_new_score (r_score),
            .i_new_role  (r_role),
            .o_key       (w_key[g]),
            .o_score     (w_score[g]),
            .o_role      (w_role[g]),
            .o_pin       (w_pin[g]),
            .o_use       (w_use[g])
        );
    end

    // ---------------------------------------------------------------
    // Head of ring during scan: entry r_k
    // ---------------------------------------------------------------
    logic head_valid;
    logic head_role_hit;
    logic head_weaker;
    logic head_key_hit;
    logic scan_last;

    assign head_valid    = CNT_W'(r_k) < r_count;
    assign head_role_hit = head_valid && (w_role[0] == r_role);
    assign head_weaker   = head_role_hit && !w_pin[0]
                           && (!r_weak_found || (w_score[0] < r_weak_score));
    assign head_key_hit  = head_valid && !r_found && (w_key[0] == r_key);
    assign scan_last     = (32'(r_k) == TABLE_ENTRIES - 1);

    // ---------------------------------------------------------------
    // Decision for the apply cycle
    // ---------------------------------------------------------------
    logic        role_ok;
    logic        class_full;
    logic [2:0]  d_status;
    logic        d_evict;
    logic [31:0] d_evkey;
    logic [4:0]  d_rc;
    logic [15:0] d_uses;
    logic        d_append;
    logic        d_drop;
    logic        d_mod_pin;
    logic        d_mod_use;

    assign role_ok = 32'(r_role) < ROLE_COUNT;

    // cap is role_cap clamped to 1..MAX_PER_ROLE
    assign class_full = (r_role_cap == 5'd0) ? (r_cnt != '0)
                      : ((32'(r_cnt) >= 32'(r_role_cap)) || (32'(r_cnt) >= MAX_PER_ROLE));

    always_comb begin
        d_status   = stap_pkg::ST_DONE;
        d_evict    = 1'b0;
        d_evkey    = 32'd0;
        d_rc       = 5'd0;
        d_uses     = 16'd0;
        d_append   = 1'b0;
        d_drop     = 1'b0;
        d_drop_pos = r_fpos;
        d_mod_pin  = 1'b0;
        d_mod_use  = 1'b0;
        d_mod_pos  = r_fpos;
        d_wr_pos   = IDX_W'(r_count);
        unique case (r_cmd)
            stap_pkg::CMD_INGEST: begin
                if (r_score < r_threshold) begin
                    d_status = stap_pkg::ST_BELOW;
                end else if (!role_ok) begin
                    d_status = stap_pkg::ST_NOT_BETTER;
                end else if (class_full) begin
                    if (!r_weak_found) begin
                        d_status = stap_pkg::ST_ALL_PINNED;
                    end else if (r_score <= r_weak_score) begin
                        d_status = stap_pkg::ST_NOT_BETTER;
                    end else begin
                        // evict the weakest, then append at the new tail
                        d_evict    = 1'b1;
                        d_evkey    = 32'(r_weak_key);
                        d_drop     = 1'b1;
                        d_drop_pos = r_weak_pos;
                        d_append   = 1'b1;
                        d_wr_pos   = IDX_W'(r_count - 1'b1);
                    end
                end else if (32'(r_count) >= TABLE_ENTRIES) begin
                    d_status = stap_pkg::ST_NOT_BETTER;
                end else begin
                    d_append = 1'b1;
                end
            end
            stap_pkg::CMD_USE: begin
                if (!r_found) begin
                    d_status = stap_pkg::ST_NOT_FOUND;
                end else begin
                    d_mod_use = 1'b1;
                    d_uses    = (r_fuse == stap_pkg::USE_MAX) ? r_fuse : r_fuse + 16'd1;
                end
            end
            stap_pkg::CMD_PIN: begin
                if (!r_found) begin
                    d_status = stap_pkg::ST_NOT_FOUND;
                end else begin
                    d_mod_pin = 1'b1;
                end
            end
            stap_pkg::CMD_REMOVE: begin
                if (!r_found) begin
                    d_status = stap_pkg::ST_NOT_FOUND;
                end else if (r_fpin) begin
                    d_status = stap_pkg::ST_PINNED;
                end else begin
                    d_drop = 1'b1;
                end
            end
            stap_pkg::CMD_COUNT: begin
                if (role_ok) begin
                    d_rc = (32'(r_cnt) > 31) ? 5'd31 : 5'(r_cnt);
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // FSM: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stap_pkg::S_IDLE:  if (start) n_state = stap_pkg::S_SCAN;
            stap_pkg::S_SCAN:  if (scan_last) n_state = stap_pkg::S_APPLY;
            stap_pkg::S_APPLY: n_state = stap_pkg::S_IDLE;
            default:           n_state = stap_pkg::S_IDLE;
        endcase
    end

    // FSM: outputs to the ring
    always_comb begin
        cell_ctrl.op      = stap_pkg::CELL_HOLD;
        cell_ctrl.drop_en = 1'b0;
        cell_ctrl.wr_en   = 1'b0;
        cell_ctrl.mod_pin = 1'b0;
        cell_ctrl.mod_use = 1'b0;
        cell_ctrl.pin_val = r_fav;
        unique case (r_state)
            stap_pkg::S_IDLE: begin
            end
            stap_pkg::S_SCAN: begin
                cell_ctrl.op = stap_pkg::CELL_ROTATE;
            end
            stap_pkg::S_APPLY: begin
                cell_ctrl.op      = stap_pkg::CELL_APPLY;
                cell_ctrl.drop_en = d_drop;
                cell_ctrl.wr_en   = d_append;
                cell_ctrl.mod_pin = d_mod_pin;
                cell_ctrl.mod_use = d_mod_use;
            end
            default: begin
            end
        endcase
    end

    assign busy        = (r_state != stap_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stap_pkg::S_IDLE;
            r_threshold <= 16'd32768;
            r_role_cap  <= 5'd16;
            r_count     <= '0;
            r_res_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= (r_state == stap_pkg::S_APPLY);
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    stap_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data;
                    stap_pkg::REG_ROLE_CAP:  r_role_cap  <= i_cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
            // advance the scan index with the ring, wrap to zero at the end
            if (r_state == stap_pkg::S_SCAN) begin
                r_k <= scan_last ? '0 : r_k + 1'b1;
            end
            if (r_state == stap_pkg::S_APPLY) begin
                if (d_drop && !d_append) begin
                    r_count <= r_count - 1'b1;
                end else if (d_append && !d_drop) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Request capture, scan accumulators and result payload
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == stap_pkg::S_IDLE) begin
            // hold the request and clear the accumulators
            r_cmd        <= i_command;
            r_role       <= i_entry_role;
            r_score      <= i_entry_score;
            r_key        <= i_entry_key[KEY_BITS-1:0];
            r_fav        <= i_favorite_value;
            r_cnt        <= '0;
            r_weak_found <= 1'b0;
            r_found      <= 1'b0;
        end
        if (r_state == stap_pkg::S_SCAN) begin
            if (head_role_hit) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (head_weaker) begin
                r_weak_found <= 1'b1;
                r_weak_pos   <= r_k;
                r_weak_score <= w_score[0];
                r_weak_key   <= w_key[0];
            end
            if (head_key_hit) begin
                r_found <= 1'b1;
                r_fpos  <= r_k;
                r_fpin  <= w_pin[0];
                r_fuse  <= w_use[0];
            end
        end
        if (r_state == stap_pkg::S_APPLY) begin
            r_res_status  <= d_status;
            r_res_evicted <= d_evict;
            r_res_evkey   <= d_evkey;
            r_res_rc      <= d_rc;
            r_res_uses    <= d_uses;
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_status       = r_res_status;
    assign o_evicted      = r_res_evicted;
    assign o_evicted_key  = r_res_evkey;
    assign o_role_count   = r_res_rc;
    assign o_use_count    = r_res_uses;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `STAP_ASSERT_NXT(a_apply_strobes, r_state == stap_pkg::S_APPLY, o_result_valid, "no result after apply")
    `STAP_ASSERT_NOW(a_count_bound, 1'b1, 32'(r_count) <= TABLE_ENTRIES, "entry count overflow")
    `STAP_ASSERT_NOW(a_evict_done, o_result_valid && o_evicted, o_status == stap_pkg::ST_DONE, "evict with error status")
    `STAP_ASSERT_NXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")
    `STAP_ASSERT_NOW(a_scan_aligned, r_state != stap_pkg::S_SCAN, r_k == '0, "ring not aligned outside scan")

endmodule

`default_nettype wire

// ===== verif/scored_table_admission_policy_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for scored_table_admission_policy_core: admission, eviction,
// pin, use, remove and class count requests against an in-bench table model.
// Depends on stap_pkg and the core RTL.

module scored_table_admission_policy_core_tb;

    localparam int SLOTS    = 128;
    localparam int CLASSES  = 8;
    localparam int CAP_MAX  = 16;
    localparam int WATCHDOG = 5000;

    typedef struct {
        logic [2:0]  status;
        logic        evicted;
        logic [31:0] evicted_key;
        logic [4:0]  role_count;
        logic [15:0] use_count;
    } t_answer;

    // Table model plus the queue of answers still owed by the core.
    class admission_scoreboard;
        logic [31:0] key_q[SLOTS];
        logic [15:0] score_q[SLOTS];
        logic [2:0]  role_q[SLOTS];
        logic        pin_q[SLOTS];
        logic [15:0] uses_q[SLOTS];
        int          fill;
        logic [15:0] threshold;
        logic [4:0]  cap_reg;
        t_answer     owed[$];
        int          errors;
        int          answered;
        int          evictions;

        function new();
            fill = 0;
            threshold = 16'd32768;
            cap_reg = 5'd16;
            errors = 0;
            answered = 0;
            evictions = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            if (idx == stap_pkg::REG_THRESHOLD) threshold = data;
            else if (idx == stap_pkg::REG_ROLE_CAP) cap_reg = data[4:0];
        endfunction

        function void close_gap(int pos);
            for (int i = pos; i + 1 < fill; i++) begin
                key_q[i] = key_q[i+1];
                score_q[i] = score_q[i+1];
                role_q[i] = role_q[i+1];
                pin_q[i] = pin_q[i+1];
                uses_q[i] = uses_q[i+1];
            end
            fill--;
        endfunction

        function int find_key(logic [31:0] k);
            for (int i = 0; i < fill; i++)
                if (key_q[i] == k) return i;
            return -1;
        endfunction

        // Apply one request to the table and queue the answer it must produce.
        function void note_request(logic [2:0] cmd, logic [2:0] role, logic [15:0] score,
                                   logic [31:0] k, logic fav);
            t_answer a;
            int cap, cnt, low_pos, pos;
            a = '{stap_pkg::ST_DONE, 1'b0, 32'd0, 5'd0, 16'd0};
            cap = cap_reg;
            if (cap < 1) cap = 1;
            if (cap > CAP_MAX) cap = CAP_MAX;
            case (cmd)
                stap_pkg::CMD_INGEST: begin
                    if (score < threshold) begin
                        a.status = stap_pkg::ST_BELOW;
                    end else if (int'(role) >= CLASSES) begin
                        a.status = stap_pkg::ST_NOT_BETTER;
                    end else begin
                        cnt = 0;
                        low_pos = -1;
                        for (int i = 0; i < fill; i++) begin
                            if (role_q[i] != role) continue;
                            cnt++;
                            if (pin_q[i]) continue;
                            if (low_pos < 0 || score_q[i] < score_q[low_pos]) low_pos = i;
                        end
                        if (cnt >= cap) begin
                            if (low_pos < 0) a.status = stap_pkg::ST_ALL_PINNED;
                            else if (score <= score_q[low_pos])
                                a.status = stap_pkg::ST_NOT_BETTER;
                            else begin
                                a.evicted = 1'b1;
                                a.evicted_key = key_q[low_pos];
                                evictions++;
                                close_gap(low_pos);
                            end
                        end
                        if (a.status == stap_pkg::ST_DONE && fill >= SLOTS)
                            a.status = stap_pkg::ST_NOT_BETTER;
                        if (a.status == stap_pkg::ST_DONE) begin
                            key_q[fill] = k;
                            score_q[fill] = score;
                            role_q[fill] = role;
                            pin_q[fill] = 1'b0;
                            uses_q[fill] = 16'd0;
                            fill++;
                        end
                    end
                end
                stap_pkg::CMD_USE: begin
                    pos = find_key(k);
                    if (pos < 0) a.status = stap_pkg::ST_NOT_FOUND;
                    else begin
                        if (uses_q[pos] != stap_pkg::USE_MAX) uses_q[pos]++;
                        a.use_count = uses_q[pos];
                    end
                end
                stap_pkg::CMD_PIN: begin
                    pos = find_key(k);
                    if (pos < 0) a.status = stap_pkg::ST_NOT_FOUND;
                    else pin_q[pos] = fav;
                end
                stap_pkg::CMD_REMOVE: begin
                    pos = find_key(k);
                    if (pos < 0) a.status = stap_pkg::ST_NOT_FOUND;
                    else if (pin_q[pos]) a.status = stap_pkg::ST_PINNED;
                    else close_gap(pos);
                end
                stap_pkg::CMD_COUNT: begin
                    cnt = 0;
                    if (int'(role) < CLASSES)
                        for (int i = 0; i < fill; i++)
                            if (role_q[i] == role) cnt++;
                    a.role_count = (cnt > 31) ? 5'd31 : cnt[4:0];
                end
                default: ;
            endcase
            owed = {owed, a};
        endfunction

        function void check_result(t_answer got);
            t_answer want;
            answered++;
            if (owed.size() == 0) begin
                $error("result strobe with no request outstanding");
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.evicted !== want.evicted) begin
                $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                errors++;
            end
            if (got.evicted_key !== want.evicted_key) begin
                $error("evicted_key: expected %h, got %h", want.evicted_key, got.evicted_key);
                errors++;
            end
            if (got.role_count !== want.role_count) begin
                $error("role_count: expected %0d, got %0d", want.role_count, got.role_count);
                errors++;
            end
            if (got.use_count !== want.use_count) begin
                $error("use_count: expected %0d, got %0d", want.use_count, got.use_count);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_command;
    logic [2:0]  i_entry_role;
    logic [15:0] i_entry_score;
    logic [31:0] i_entry_key;
    logic        i_favorite_value;
    logic        o_result_valid;
    logic [2:0]  o_status;
    logic        o_evicted;
    logic [31:0] o_evicted_key;
    logic [4:0]  o_role_count;
    logic [15:0] o_use_count;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    scored_table_admission_policy_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_entry_role     (i_entry_role),
        .i_entry_score    (i_entry_score),
        .i_entry_key      (i_entry_key),
        .i_favorite_value (i_favorite_value),
        .o_result_valid   (o_result_valid),
        .o_status         (o_status),
        .o_evicted        (o_evicted),
        .o_evicted_key    (o_evicted_key),
        .o_role_count     (o_role_count),
        .o_use_count      (o_use_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    admission_scoreboard sb = new();

    int          gap_pct;     // chance in percent that the sender idles a cycle
    int          sent;
    int          stall_cycles;
    logic [31:0] key_pool[32];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Check every result strobe; end the run if no handshake of any kind
    // completes for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid)
                sb.check_result('{o_status, o_evicted, o_evicted_key, o_role_count,
                                  o_use_count});
            if (o_result_valid || (start && !busy) || (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Offer one request, idling first at random; start stays high into the
    // next request unless that one idles.
    task automatic send_request(logic [2:0] cmd, logic [2:0] role, logic [15:0] score,
                                logic [31:0] k, logic fav);
        while ($urandom_range(99) < gap_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_command = cmd;
        i_entry_role = role;
        i_entry_score = score;
        i_entry_key = k;
        i_favorite_value = fav;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_request(cmd, role, score, k, fav);
        sent++;
        @(negedge i_clk);
    endtask

    // Drain all answers, let the scan in flight finish, then write a register.
    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        start = 1'b0;
        while (sb.owed.size() != 0) @(negedge i_clk);
        repeat (SLOTS + 8) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(19) == 0) return $urandom();
        return key_pool[$urandom_range(31)];
    endfunction

    // Mostly admissible scores so classes fill and evict; some below the bar.
    function automatic logic [15:0] pick_score();
        int thr;
        thr = sb.threshold;
        if ($urandom_range(4) == 0) return 16'($urandom());
        return 16'(thr + $urandom_range(65535 - thr));
    endfunction

    task automatic random_burst(int count);
        int sel;
        logic [2:0] cmd;
        for (int n = 0; n < count; n++) begin
            // Hold the sender idle pattern by position in the whole run.
            if (sent < 670) gap_pct = 26;
            else if (sent < 1340) gap_pct = 58;
            else gap_pct = 0;
            sel = $urandom_range(99);
            if (sel < 42) cmd = stap_pkg::CMD_INGEST;
            else if (sel < 57) cmd = stap_pkg::CMD_USE;
            else if (sel < 72) cmd = stap_pkg::CMD_PIN;
            else if (sel < 86) cmd = stap_pkg::CMD_REMOVE;
            else if (sel < 96) cmd = stap_pkg::CMD_COUNT;
            else cmd = 3'($urandom_range(5, 7));
            send_request(cmd, 3'($urandom()), pick_score(), pick_key(), 1'($urandom()));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_command = stap_pkg::CMD_INGEST;
        i_entry_role = '0;
        i_entry_score = '0;
        i_entry_key = '0;
        i_favorite_value = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = stap_pkg::REG_THRESHOLD;
        i_cfg_data = '0;
        gap_pct = 26;
        sent = 0;
        stall_cycles = 0;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 32; i++) key_pool[i] = $urandom();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: a few requests at reset settings, then a tiny cap to reach
        // eviction, ties, all-pinned and pinned-refusal quickly.
        send_request(stap_pkg::CMD_INGEST, 3'd0, 16'd32767, 32'h1111_0000, 1'b0);
        send_request(stap_pkg::CMD_INGEST, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(stap_pkg::CMD_COUNT, 3'd7, 16'd0, 32'd0, 1'b0);
        write_reg(stap_pkg::REG_THRESHOLD, 16'd100);
        write_reg(stap_pkg::REG_ROLE_CAP, 16'd2);
        send_request(stap_pkg::CMD_INGEST, 3'd1, 16'd100, 32'h0000_0000, 1'b0);
        send_request(stap_pkg::CMD_INGEST, 3'd1, 16'd300, 32'h0000_00B0, 1'b0);
        send_request(stap_pkg::CMD_INGEST, 3'd1, 16'd99, 32'h0000_00C0, 1'b0);
        send_request(stap_pkg::CMD_INGEST, 3'd1, 16'd100, 32'h0000_00C0, 1'b0);
        send_request(stap_pkg::CMD_INGEST, 3'd1, 16'd400, 32'h0000_00D0, 1'b0);
        send_request(stap_pkg::CMD_USE, 3'd0, 16'd0, 32'h0000_00B0, 1'b0);
        send_request(stap_pkg::CMD_USE, 3'd0, 16'd0, 32'h0000_00B0, 1'b0);
        send_request(stap_pkg::CMD_PIN, 3'd0, 16'd0, 32'h0000_00B0, 1'b1);
        send_request(stap_pkg::CMD_PIN, 3'd0, 16'd0, 32'h0000_00D0, 1'b1);
        send_request(stap_pkg::CMD_INGEST, 3'd1, 16'hFFFF, 32'h0000_00E0, 1'b0);
        send_request(stap_pkg::CMD_REMOVE, 3'd0, 16'd0, 32'h0000_00B0, 1'b0);
        send_request(stap_pkg::CMD_PIN, 3'd0, 16'd0, 32'h0000_00B0, 1'b0);
        send_request(stap_pkg::CMD_REMOVE, 3'd0, 16'd0, 32'h0000_00B0, 1'b0);
        send_request(stap_pkg::CMD_REMOVE, 3'd0, 16'd0, 32'h0000_00B0, 1'b0);
        send_request(stap_pkg::CMD_USE, 3'd0, 16'd0, 32'h1234_5678, 1'b0);
        send_request(stap_pkg::CMD_COUNT, 3'd1, 16'd0, 32'd0, 1'b0);
        send_request(3'd5, 3'd1, 16'hFFFF, 32'h0000_00D0, 1'b1);
        send_request(3'd6, 3'd2, 16'd0, 32'd0, 1'b0);
        send_request(3'd7, 3'd3, 16'd5, 32'd1, 1'b1);

        // Random phases across the register extremes and out-of-range caps.
        write_reg(stap_pkg::REG_THRESHOLD, 16'd0);
        write_reg(stap_pkg::REG_ROLE_CAP, 16'd16);
        random_burst(330);
        write_reg(stap_pkg::REG_ROLE_CAP, 16'd0);
        random_burst(260);
        write_reg(stap_pkg::REG_THRESHOLD, 16'hFFFF);
        write_reg(stap_pkg::REG_ROLE_CAP, 16'hFFFF);
        random_burst(140);
        write_reg(stap_pkg::REG_THRESHOLD, 16'd20000);
        write_reg(stap_pkg::REG_ROLE_CAP, 16'd3);
        random_burst(320);
        write_reg(stap_pkg::REG_THRESHOLD, 16'($urandom()));
        write_reg(stap_pkg::REG_ROLE_CAP, 16'd17);
        random_burst(300);
        write_reg(stap_pkg::REG_THRESHOLD, 16'($urandom_range(4000)));
        write_reg(stap_pkg::REG_ROLE_CAP, 16'($urandom_range(1, 6)));
        random_burst(580);

        // Drain, then allow the last scan to settle.
        start = 1'b0;
        while (sb.owed.size() != 0) @(negedge i_clk);
        repeat (SLOTS + 8) @(negedge i_clk);

        $display("covered %0d requests, %0d results checked, %0d evictions",
                 sent, sb.answered, sb.evictions);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
